FILE: rtl/core/iac_pkg.sv
`timescale 1ns / 1ps

package iac_pkg;

    // security states, coded as reported on alarm_state
    typedef enum logic [2:0] {
        SEC_DISARMED  = 3'd0,
        SEC_ARMING    = 3'd1,
        SEC_ARMED     = 3'd2,
        SEC_INTRUSION = 3'd3,
        SEC_ALARM     = 3'd4
    } sec_state_t;

    // remote command codes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_ARM    = 2'd1;
    localparam logic [1:0] MODE_DISARM = 2'd2;

    // command answer codes
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_ACCEPTED = 2'd1;
    localparam logic [1:0] CMD_REJECTED = 2'd2;

    // beep counts
    localparam logic [2:0] BEEP_NONE   = 3'd0;
    localparam logic [2:0] BEEP_DISARM = 3'd1;
    localparam logic [2:0] BEEP_CANCEL = 3'd2;
    localparam logic [2:0] BEEP_ARM    = 3'd3;
    localparam logic [2:0] BEEP_ARMED  = 3'd5;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
    localparam logic [2:0] REG_EXIT_DELAY   = 3'd2;
    localparam logic [2:0] REG_GRACE        = 3'd3;
    localparam logic [2:0] REG_SOUND_LIMIT  = 3'd4;
    localparam logic [2:0] REG_NEAR_LOW     = 3'd5;
    localparam logic [2:0] REG_NEAR_HIGH    = 3'd6;
    localparam logic [2:0] REG_SENSOR_PER   = 3'd7;
    localparam int         APB_ADDR_W       = 5;

    // register reset values
    localparam logic [9:0]  RST_DEBOUNCE    = 10'd50;
    localparam logic [15:0] RST_LONG_PRESS  = 16'd5000;
    localparam logic [15:0] RST_EXIT_DELAY  = 16'd20000;
    localparam logic [15:0] RST_GRACE       = 16'd30000;
    localparam logic [11:0] RST_SOUND_LIMIT = 12'd200;
    localparam logic [11:0] RST_NEAR_LOW    = 12'd249;
    localparam logic [11:0] RST_NEAR_HIGH   = 12'd695;
    localparam logic [9:0]  RST_SENSOR_PER  = 10'd100;

    // timing constants in ms
    localparam logic [12:0] COUNTDOWN_LAST   = 13'd4999;
    localparam logic [12:0] COUNTDOWN_CHIRP  = 13'd100;
    localparam logic [9:0]  WARN_CHIRP       = 10'd50;
    localparam logic [9:0]  WARN_HALF        = 10'd500;
    localparam logic [9:0]  WARN_HALF_CHIRP  = 10'd550;
    localparam logic [8:0]  SIREN_HALF       = 9'd500;
    localparam logic [9:0]  BLINK_LAST       = 10'd999;
    localparam logic [9:0]  ARMING_ON        = 10'd500;
    localparam logic [7:0]  FAST_LAST        = 8'd249;
    localparam logic [7:0]  FAST_ON          = 8'd125;
    localparam logic [6:0]  ALARM_LAST       = 7'd99;
    localparam logic [6:0]  ALARM_ON         = 7'd50;

    typedef struct packed {
        logic [9:0]  debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] exit_delay_ms;
        logic [15:0] grace_ms;
        logic [11:0] sound_limit;
        logic [11:0] near_low_raw;
        logic [11:0] near_high_raw;
        logic [9:0]  sensor_period_ms;
    } cfg_t;

    typedef struct packed {
        sec_state_t  sec;
        logic        light_flag;
        logic        alarm_flag;
        logic        prev_touch_raw;
        logic        stable_touch;
        logic [15:0] debounce_count;
        logic [15:0] press_count;
        logic        long_seen;
        logic [15:0] state_timer;
        logic [12:0] countdown_phase;  // state_timer modulo 5000 while arming
        logic [9:0]  sensor_timer;
        logic [9:0]  blink_phase;
        logic [7:0]  blink_mod250;
        logic [6:0]  blink_mod100;
        logic [8:0]  siren_timer;
        logic        siren_pitch;
    } core_state_t;

    // controller state after reset: disarmed, siren on high tone
    localparam core_state_t CORE_RST = '{
        sec:             SEC_DISARMED,
        light_flag:      1'b0,
        alarm_flag:      1'b0,
        prev_touch_raw:  1'b0,
        stable_touch:    1'b0,
        debounce_count:  16'd0,
        press_count:     16'd0,
        long_seen:       1'b0,
        state_timer:     16'd0,
        countdown_phase: 13'd0,
        sensor_timer:    10'd0,
        blink_phase:     10'd0,
        blink_mod250:    8'd0,
        blink_mod100:    7'd0,
        siren_timer:     9'd0,
        siren_pitch:     1'b1
    };

    typedef struct packed {
        logic        touch_raw;
        logic [11:0] sound_level;
        logic [11:0] distance_raw;
        logic [1:0]  mode;
    } in_word_t;

    typedef struct packed {
        logic [2:0] alarm_state;
        logic       lamp_drive;
        logic       light_on;
        logic       alarm_active;
        logic       siren_on;
        logic       siren_high;
        logic       chirp;
        logic [2:0] beep_count;
        logic       status_changed;
        logic [1:0] command_status;
    } out_word_t;

endpackage

FILE: rtl/core/intrusion_alarm_controller_core.sv
`timescale 1ns / 1ps

// Intrusion alarm controller core.
// Input channel (in_valid/in_ready): one word per millisecond tick with the
// raw touch level, sound sample, ultrasonic sample and remote command mode.
// Output channel (out_valid/out_ready): one result word per input word with
// the security state, lamp level, light and alarm flags, siren on/tone,
// chirp request, beep count, status-changed flag and command answer.
// A word accepted into the input register is processed combinationally and
// its result is loaded into the result register once that register has room;
// it stays on the outputs until the receiver takes it with out_ready high.
// Throughput: one word per cycle unless the receiver stalls; the whole tick
// update is a single pass of counter/compare logic from input to result register.
// If the receiver stalls, the result register holds its word, the input
// register still takes one more word, and in_ready drops until the result
// is taken. Reset clears both valid flags, loads the register defaults and
// puts the controller in the disarmed state with the siren on high tone.
// Registers are written over the APB port at byte address 4 * index.
module intrusion_alarm_controller_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        touch_raw,
    input  logic [11:0] sound_level,
    input  logic [11:0] distance_raw,
    input  logic [1:0]  mode,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  alarm_state,
    output logic        lamp_drive,
    output logic        light_on,
    output logic        alarm_active,
    output logic        siren_on,
    output logic        siren_high,
    output logic        chirp,
    output logic [2:0]  beep_count,
    output logic        status_changed,
    output logic [1:0]  command_status,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iac_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    iac_pkg::cfg_t        cfg_reg;
    iac_pkg::core_state_t state_reg;
    iac_pkg::core_state_t state_next;
    iac_pkg::in_word_t    in_word_reg;
    logic                 in_valid_reg;
    iac_pkg::out_word_t   out_word_reg;
    iac_pkg::out_word_t   out_word_next;
    logic                 out_valid_reg;
    logic                 step_go;
    logic                 in_take;
    logic                 cfg_write;
    logic [2:0]           reg_index;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_index = paddr[iac_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= iac_pkg::RST_DEBOUNCE;
            cfg_reg.long_press_ms    <= iac_pkg::RST_LONG_PRESS;
            cfg_reg.exit_delay_ms    <= iac_pkg::RST_EXIT_DELAY;
            cfg_reg.grace_ms         <= iac_pkg::RST_GRACE;
            cfg_reg.sound_limit      <= iac_pkg::RST_SOUND_LIMIT;
            cfg_reg.near_low_raw     <= iac_pkg::RST_NEAR_LOW;
            cfg_reg.near_high_raw    <= iac_pkg::RST_NEAR_HIGH;
            cfg_reg.sensor_period_ms <= iac_pkg::RST_SENSOR_PER;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                iac_pkg::REG_DEBOUNCE:    cfg_reg.debounce_ms      <= pwdata[9:0];
                iac_pkg::REG_LONG_PRESS:  cfg_reg.long_press_ms    <= pwdata[15:0];
                iac_pkg::REG_EXIT_DELAY:  cfg_reg.exit_delay_ms    <= pwdata[15:0];
                iac_pkg::REG_GRACE:       cfg_reg.grace_ms         <= pwdata[15:0];
                iac_pkg::REG_SOUND_LIMIT: cfg_reg.sound_limit      <= pwdata[11:0];
                iac_pkg::REG_NEAR_LOW:    cfg_reg.near_low_raw     <= pwdata[11:0];
                iac_pkg::REG_NEAR_HIGH:   cfg_reg.near_high_raw    <= pwdata[11:0];
                iac_pkg::REG_SENSOR_PER:  cfg_reg.sensor_period_ms <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (reg_index)
            iac_pkg::REG_DEBOUNCE:    prdata = {22'd0, cfg_reg.debounce_ms};
            iac_pkg::REG_LONG_PRESS:  prdata = {16'd0, cfg_reg.long_press_ms};
            iac_pkg::REG_EXIT_DELAY:  prdata = {16'd0, cfg_reg.exit_delay_ms};
            iac_pkg::REG_GRACE:       prdata = {16'd0, cfg_reg.grace_ms};
            iac_pkg::REG_SOUND_LIMIT: prdata = {20'd0, cfg_reg.sound_limit};
            iac_pkg::REG_NEAR_LOW:    prdata = {20'd0, cfg_reg.near_low_raw};
            iac_pkg::REG_NEAR_HIGH:   prdata = {20'd0, cfg_reg.near_high_raw};
            iac_pkg::REG_SENSOR_PER:  prdata = {22'd0, cfg_reg.sensor_period_ms};
            default:                  prdata = 32'd0;
        endcase
    end

    // handshake: input register feeds result register whenever it has room
    assign step_go  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_go;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_go)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg.touch_raw    <= touch_raw;
            in_word_reg.sound_level  <= sound_level;
            in_word_reg.distance_raw <= distance_raw;
            in_word_reg.mode         <= mode;
        end
    end

    // tick update
    iac_step u_step
    (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .din  (in_word_reg),
        .nxt  (state_next),
        .dout (out_word_next)
    );

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iac_pkg::CORE_RST;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign alarm_state    = out_word_reg.alarm_state;
    assign lamp_drive     = out_word_reg.lamp_drive;
    assign light_on       = out_word_reg.light_on;
    assign alarm_active   = out_word_reg.alarm_active;
    assign siren_on       = out_word_reg.siren_on;
    assign siren_high     = out_word_reg.siren_high;
    assign chirp          = out_word_reg.chirp;
    assign beep_count     = out_word_reg.beep_count;
    assign status_changed = out_word_reg.status_changed;
    assign command_status = out_word_reg.command_status;

endmodule

FILE: rtl/core/iac_step.sv
`timescale 1ns / 1ps

// One millisecond tick: next controller state and the result word.
module iac_step
(
    input  iac_pkg::cfg_t        cfg,
    input  iac_pkg::core_state_t cur,
    input  iac_pkg::in_word_t    din,
    output iac_pkg::core_state_t nxt,
    output iac_pkg::out_word_t   dout
);

    always_comb
    begin
        iac_pkg::core_state_t s;
        logic       chirp;
        logic [2:0] beeps;
        logic       changed;
        logic [1:0] cmd;
        logic       lamp;
        logic       hit;

        s       = cur;
        chirp   = 1'b0;
        beeps   = iac_pkg::BEEP_NONE;
        changed = 1'b0;
        cmd     = iac_pkg::CMD_NONE;
        lamp    = 1'b0;
        hit     = 1'b0;

        // ms counters: the timers saturate, the countdown phase wraps
        s.state_timer = (cur.state_timer == 16'hFFFF) ? 16'hFFFF : cur.state_timer + 16'd1;
        s.countdown_phase = (cur.countdown_phase == iac_pkg::COUNTDOWN_LAST) ? 13'd0
                          : cur.countdown_phase + 13'd1;
        s.sensor_timer = (cur.sensor_timer == 10'h3FF) ? 10'h3FF : cur.sensor_timer + 10'd1;
        if (cur.stable_touch)
        begin
            s.press_count = (cur.press_count == 16'hFFFF) ? 16'hFFFF
                          : cur.press_count + 16'd1;
        end
        if (din.touch_raw != cur.prev_touch_raw)
        begin
            s.debounce_count = 16'd0;
        end
        else
        begin
            s.debounce_count = (cur.debounce_count == 16'hFFFF) ? 16'hFFFF
                             : cur.debounce_count + 16'd1;
        end

        // debounced edge: press start or short-press release
        if (s.debounce_count > {6'd0, cfg.debounce_ms} && din.touch_raw != s.stable_touch)
        begin
            s.stable_touch = din.touch_raw;
            if (din.touch_raw)
            begin
                s.press_count = 16'd0;
                s.long_seen   = 1'b0;
            end
            else if (!s.long_seen && s.press_count < cfg.long_press_ms
                     && s.sec == iac_pkg::SEC_DISARMED)
            begin
                s.light_flag = ~s.light_flag;
                changed      = 1'b1;
            end
        end

        // long press
        if (s.stable_touch && !s.long_seen && s.press_count >= cfg.long_press_ms)
        begin
            s.long_seen = 1'b1;
            changed     = 1'b1;
            case (s.sec)
                iac_pkg::SEC_DISARMED:
                begin
                    s.sec             = iac_pkg::SEC_ARMING;
                    s.state_timer     = 16'd0;
                    s.countdown_phase = 13'd0;
                    beeps             = iac_pkg::BEEP_ARM;
                end
                iac_pkg::SEC_ARMING, iac_pkg::SEC_ARMED:
                begin
                    s.sec        = iac_pkg::SEC_DISARMED;
                    s.light_flag = 1'b0;
                    beeps        = iac_pkg::BEEP_DISARM;
                end
                iac_pkg::SEC_INTRUSION:
                begin
                    s.sec = iac_pkg::SEC_DISARMED;
                    beeps = iac_pkg::BEEP_CANCEL;
                end
                default:
                begin
                    s.sec        = iac_pkg::SEC_DISARMED;
                    s.alarm_flag = 1'b0;
                    beeps        = iac_pkg::BEEP_DISARM;
                end
            endcase
        end
        s.prev_touch_raw = din.touch_raw;

        // exit delay, grace period, siren tone
        case (s.sec)
            iac_pkg::SEC_ARMING:
            begin
                if (s.state_timer >= cfg.exit_delay_ms)
                begin
                    s.sec   = iac_pkg::SEC_ARMED;
                    beeps   = iac_pkg::BEEP_ARMED;
                    changed = 1'b1;
                end
                else if (s.countdown_phase < iac_pkg::COUNTDOWN_CHIRP)
                begin
                    chirp = 1'b1;
                end
            end
            iac_pkg::SEC_INTRUSION:
            begin
                if (s.state_timer >= cfg.grace_ms)
                begin
                    s.sec         = iac_pkg::SEC_ALARM;
                    s.alarm_flag  = 1'b1;
                    s.siren_timer = 9'd0;
                    s.siren_pitch = 1'b1;
                    changed       = 1'b1;
                end
                else if (cur.blink_phase < iac_pkg::WARN_CHIRP
                         || (cur.blink_phase >= iac_pkg::WARN_HALF
                             && cur.blink_phase < iac_pkg::WARN_HALF_CHIRP))
                begin
                    chirp = 1'b1;
                end
            end
            iac_pkg::SEC_ALARM:
            begin
                if (s.siren_timer + 9'd1 >= iac_pkg::SIREN_HALF)
                begin
                    s.siren_timer = 9'd0;
                    s.siren_pitch = ~s.siren_pitch;
                end
                else
                begin
                    s.siren_timer = s.siren_timer + 9'd1;
                end
            end
            default:
            begin
            end
        endcase

        // sensor check while armed
        if (s.sec == iac_pkg::SEC_ARMED && s.sensor_timer >= cfg.sensor_period_ms)
        begin
            hit = (din.sound_level > cfg.sound_limit)
                || (din.distance_raw >= cfg.near_low_raw
                    && din.distance_raw <= cfg.near_high_raw);
            s.sensor_timer = 10'd0;
            if (hit)
            begin
                s.sec             = iac_pkg::SEC_INTRUSION;
                s.state_timer     = 16'd0;
                s.countdown_phase = 13'd0;
                changed           = 1'b1;
            end
        end

        // remote command
        case (din.mode)
            iac_pkg::MODE_NONE:
            begin
            end
            iac_pkg::MODE_ARM:
            begin
                if (s.sec == iac_pkg::SEC_DISARMED)
                begin
                    s.sec             = iac_pkg::SEC_ARMING;
                    s.state_timer     = 16'd0;
                    s.countdown_phase = 13'd0;
                    beeps             = iac_pkg::BEEP_ARM;
                    changed           = 1'b1;
                    cmd               = iac_pkg::CMD_ACCEPTED;
                end
                else
                begin
                    cmd = iac_pkg::CMD_REJECTED;
                end
            end
            iac_pkg::MODE_DISARM:
            begin
                if (s.sec != iac_pkg::SEC_DISARMED)
                begin
                    s.sec        = iac_pkg::SEC_DISARMED;
                    s.alarm_flag = 1'b0;
                    s.light_flag = 1'b0;
                    beeps        = iac_pkg::BEEP_DISARM;
                    changed      = 1'b1;
                    cmd          = iac_pkg::CMD_ACCEPTED;
                end
                else
                begin
                    cmd = iac_pkg::CMD_REJECTED;
                end
            end
            default:
            begin
                cmd = iac_pkg::CMD_REJECTED;
            end
        endcase

        // lamp pattern per state, blinking from the current blink phase
        case (s.sec)
            iac_pkg::SEC_DISARMED:  lamp = s.light_flag;
            iac_pkg::SEC_ARMING:    lamp = (cur.blink_phase < iac_pkg::ARMING_ON);
            iac_pkg::SEC_ARMED:     lamp = 1'b1;
            iac_pkg::SEC_INTRUSION: lamp = (cur.blink_mod250 < iac_pkg::FAST_ON);
            iac_pkg::SEC_ALARM:     lamp = (cur.blink_mod100 < iac_pkg::ALARM_ON);
            default:                lamp = 1'b0;
        endcase

        // blink phase and its residues advance every tick
        s.blink_phase  = (cur.blink_phase == iac_pkg::BLINK_LAST) ? 10'd0
                       : cur.blink_phase + 10'd1;
        s.blink_mod250 = (cur.blink_mod250 == iac_pkg::FAST_LAST) ? 8'd0
                       : cur.blink_mod250 + 8'd1;
        s.blink_mod100 = (cur.blink_mod100 == iac_pkg::ALARM_LAST) ? 7'd0
                       : cur.blink_mod100 + 7'd1;

        nxt = s;

        dout.alarm_state    = s.sec;
        dout.lamp_drive     = lamp;
        dout.light_on       = s.light_flag;
        dout.alarm_active   = s.alarm_flag;
        dout.siren_on       = (s.sec == iac_pkg::SEC_ALARM);
        dout.siren_high     = (s.sec == iac_pkg::SEC_ALARM) && s.siren_pitch;
        dout.chirp          = chirp;
        dout.beep_count     = beeps;
        dout.status_changed = changed;
        dout.command_status = cmd;
    end

endmodule

FILE: bench/tb_intrusion_alarm_controller_core.sv
`timescale 1ns / 1ps

module tb_intrusion_alarm_controller_core;

    // remote command code with no meaning, answered as rejected
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // tick timing in ms
    localparam int unsigned T_MAX16           = 65535;
    localparam int unsigned T_MAX10           = 1023;
    localparam int unsigned T_COUNTDOWN       = 5000;
    localparam int unsigned T_COUNTDOWN_CHIRP = 100;
    localparam int unsigned T_WARN_PERIOD     = 500;
    localparam int unsigned T_WARN_CHIRP      = 50;
    localparam int unsigned T_SIREN_HALF      = 500;
    localparam int unsigned T_BLINK_PERIOD    = 1000;
    localparam int unsigned T_ARMING_LAMP     = 500;
    localparam int unsigned T_WARN_BLINK      = 250;
    localparam int unsigned T_WARN_LAMP       = 125;
    localparam int unsigned T_ALARM_BLINK     = 100;
    localparam int unsigned T_ALARM_LAMP      = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        touch_raw = 1'b0;
    logic [11:0] sound_level = '0;
    logic [11:0] distance_raw = '0;
    logic [1:0]  mode = iac_pkg::MODE_NONE;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  alarm_state;
    logic        lamp_drive;
    logic        light_on;
    logic        alarm_active;
    logic        siren_on;
    logic        siren_high;
    logic        chirp;
    logic [2:0]  beep_count;
    logic        status_changed;
    logic [1:0]  command_status;

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [iac_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // register copies seen by the predictor
    int unsigned cfg_debounce      = 32'(iac_pkg::RST_DEBOUNCE);
    int unsigned cfg_long_press    = 32'(iac_pkg::RST_LONG_PRESS);
    int unsigned cfg_exit_delay    = 32'(iac_pkg::RST_EXIT_DELAY);
    int unsigned cfg_grace         = 32'(iac_pkg::RST_GRACE);
    int unsigned cfg_sound_limit   = 32'(iac_pkg::RST_SOUND_LIMIT);
    int unsigned cfg_near_low      = 32'(iac_pkg::RST_NEAR_LOW);
    int unsigned cfg_near_high     = 32'(iac_pkg::RST_NEAR_HIGH);
    int unsigned cfg_sensor_period = 32'(iac_pkg::RST_SENSOR_PER);

    // controller state as predicted
    iac_pkg::sec_state_t m_sec = iac_pkg::SEC_DISARMED;
    logic        m_light = 1'b0;
    logic        m_alarm = 1'b0;
    logic        m_prev_raw = 1'b0;
    logic        m_stable = 1'b0;
    logic        m_long_seen = 1'b0;
    logic        m_siren_pitch = 1'b1;
    int unsigned m_debounce = 0;
    int unsigned m_press = 0;
    int unsigned m_state_timer = 0;
    int unsigned m_sensor_timer = 0;
    int unsigned m_blink = 0;
    int unsigned m_siren_timer = 0;

    iac_pkg::in_word_t  tick_queue[$];
    iac_pkg::in_word_t  tick_in;
    iac_pkg::out_word_t expected_status[$];
    iac_pkg::out_word_t oldest;

    int unsigned n_items = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    intrusion_alarm_controller_core i_dut (.*);

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned sat_up(int unsigned v, int unsigned top);
        return (v >= top) ? top : v + 1;
    endfunction

    // one ms tick of the controller; updates the predicted state
    function automatic iac_pkg::out_word_t step_alarm(iac_pkg::in_word_t w);
        iac_pkg::out_word_t r;
        logic       chirp_now;
        logic [2:0] beeps;
        logic       changed;
        logic [1:0] answer;
        logic       hit;
        logic       lamp;
        chirp_now = 1'b0;
        beeps     = iac_pkg::BEEP_NONE;
        changed   = 1'b0;
        answer    = iac_pkg::CMD_NONE;

        // ms counters
        m_state_timer  = sat_up(m_state_timer, T_MAX16);
        m_sensor_timer = sat_up(m_sensor_timer, T_MAX10);
        if (m_stable)
            m_press = sat_up(m_press, T_MAX16);
        m_debounce = (w.touch_raw != m_prev_raw) ? 0 : sat_up(m_debounce, T_MAX16);

        // debounced touch edges; a short release toggles the light when disarmed
        if (m_debounce > cfg_debounce && w.touch_raw != m_stable)
        begin
            m_stable = w.touch_raw;
            if (w.touch_raw)
            begin
                m_press     = 0;
                m_long_seen = 1'b0;
            end
            else if (!m_long_seen && m_press < cfg_long_press
                     && m_sec == iac_pkg::SEC_DISARMED)
            begin
                m_light = ~m_light;
                changed = 1'b1;
            end
        end

        // long press
        if (m_stable && !m_long_seen && m_press >= cfg_long_press)
        begin
            m_long_seen = 1'b1;
            changed     = 1'b1;
            case (m_sec)
                iac_pkg::SEC_DISARMED:
                begin
                    m_sec         = iac_pkg::SEC_ARMING;
                    m_state_timer = 0;
                    beeps         = iac_pkg::BEEP_ARM;
                end
                iac_pkg::SEC_ARMING, iac_pkg::SEC_ARMED:
                begin
                    m_sec   = iac_pkg::SEC_DISARMED;
                    m_light = 1'b0;
                    beeps   = iac_pkg::BEEP_DISARM;
                end
                iac_pkg::SEC_INTRUSION:
                begin
                    m_sec = iac_pkg::SEC_DISARMED;
                    beeps = iac_pkg::BEEP_CANCEL;
                end
                default:
                begin
                    m_sec   = iac_pkg::SEC_DISARMED;
                    m_alarm = 1'b0;
                    beeps   = iac_pkg::BEEP_DISARM;
                end
            endcase
        end
        m_prev_raw = w.touch_raw;

        // exit delay, grace period, siren tone
        case (m_sec)
            iac_pkg::SEC_ARMING:
            begin
                if (m_state_timer >= cfg_exit_delay)
                begin
                    m_sec   = iac_pkg::SEC_ARMED;
                    beeps   = iac_pkg::BEEP_ARMED;
                    changed = 1'b1;
                end
                else if (m_state_timer % T_COUNTDOWN < T_COUNTDOWN_CHIRP)
                    chirp_now = 1'b1;
            end
            iac_pkg::SEC_INTRUSION:
            begin
                if (m_state_timer >= cfg_grace)
                begin
                    m_sec         = iac_pkg::SEC_ALARM;
                    m_alarm       = 1'b1;
                    m_siren_timer = 0;
                    m_siren_pitch = 1'b1;
                    changed       = 1'b1;
                end
                else if (m_blink % T_WARN_PERIOD < T_WARN_CHIRP)
                    chirp_now = 1'b1;
            end
            iac_pkg::SEC_ALARM:
            begin
                m_siren_timer++;
                if (m_siren_timer >= T_SIREN_HALF)
                begin
                    m_siren_timer = 0;
                    m_siren_pitch = ~m_siren_pitch;
                end
            end
            default:
            begin
            end
        endcase

        // sensor check while armed
        if (m_sec == iac_pkg::SEC_ARMED && m_sensor_timer >= cfg_sensor_period)
        begin
            hit = (32'(w.sound_level) > cfg_sound_limit) ||
                  (32'(w.distance_raw) >= cfg_near_low
                   && 32'(w.distance_raw) <= cfg_near_high);
            m_sensor_timer = 0;
            if (hit)
            begin
                m_sec         = iac_pkg::SEC_INTRUSION;
                m_state_timer = 0;
                changed       = 1'b1;
            end
        end

        // remote command
        case (w.mode)
            iac_pkg::MODE_ARM:
            begin
                if (m_sec == iac_pkg::SEC_DISARMED)
                begin
                    m_sec         = iac_pkg::SEC_ARMING;
                    m_state_timer = 0;
                    beeps         = iac_pkg::BEEP_ARM;
                    changed       = 1'b1;
                    answer        = iac_pkg::CMD_ACCEPTED;
                end
                else
                    answer = iac_pkg::CMD_REJECTED;
            end
            iac_pkg::MODE_DISARM:
            begin
                if (m_sec != iac_pkg::SEC_DISARMED)
                begin
                    m_sec   = iac_pkg::SEC_DISARMED;
                    m_alarm = 1'b0;
                    m_light = 1'b0;
                    beeps   = iac_pkg::BEEP_DISARM;
                    changed = 1'b1;
                    answer  = iac_pkg::CMD_ACCEPTED;
                end
                else
                    answer = iac_pkg::CMD_REJECTED;
            end
            MODE_UNKNOWN:
                answer = iac_pkg::CMD_REJECTED;
            default:
            begin
            end
        endcase

        // lamp pattern per state
        case (m_sec)
            iac_pkg::SEC_ARMING:    lamp = (m_blink < T_ARMING_LAMP);
            iac_pkg::SEC_ARMED:     lamp = 1'b1;
            iac_pkg::SEC_INTRUSION: lamp = (m_blink % T_WARN_BLINK) < T_WARN_LAMP;
            iac_pkg::SEC_ALARM:     lamp = (m_blink % T_ALARM_BLINK) < T_ALARM_LAMP;
            default:                lamp = m_light;
        endcase

        r.alarm_state    = m_sec;
        r.lamp_drive     = lamp;
        r.light_on       = m_light;
        r.alarm_active   = m_alarm;
        r.siren_on       = (m_sec == iac_pkg::SEC_ALARM);
        r.siren_high     = (m_sec == iac_pkg::SEC_ALARM) && m_siren_pitch;
        r.chirp          = chirp_now;
        r.beep_count     = beeps;
        r.status_changed = changed;
        r.command_status = answer;

        m_blink = (m_blink + 1 >= T_BLINK_PERIOD) ? 0 : m_blink + 1;
        return r;
    endfunction

    function automatic int unsigned reg_width(logic [2:0] idx);
        case (idx)
            iac_pkg::REG_DEBOUNCE, iac_pkg::REG_SENSOR_PER:   return 10;
            iac_pkg::REG_LONG_PRESS, iac_pkg::REG_EXIT_DELAY,
            iac_pkg::REG_GRACE:                               return 16;
            default:                                          return 12;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic push_tick(input logic t, input logic [11:0] snd, input logic [11:0] dst,
                             input logic [1:0] md);
        iac_pkg::in_word_t w;
        w.touch_raw    = t;
        w.sound_level  = snd;
        w.distance_raw = dst;
        w.mode         = md;
        tick_queue.push_back(w);
        n_items++;
    endtask

    // wait until every queued word has come back as a result
    task automatic drain();
        while (n_results < n_items)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write followed by a read back of the same register
    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        int unsigned mask;
        mask = (32'd1 << reg_width(idx)) - 1;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & mask) | ($urandom() & ~mask);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            iac_pkg::REG_DEBOUNCE:    cfg_debounce      = value & mask;
            iac_pkg::REG_LONG_PRESS:  cfg_long_press    = value & mask;
            iac_pkg::REG_EXIT_DELAY:  cfg_exit_delay    = value & mask;
            iac_pkg::REG_GRACE:       cfg_grace         = value & mask;
            iac_pkg::REG_SOUND_LIMIT: cfg_sound_limit   = value & mask;
            iac_pkg::REG_NEAR_LOW:    cfg_near_low      = value & mask;
            iac_pkg::REG_NEAR_HIGH:   cfg_near_high     = value & mask;
            default:                  cfg_sensor_period = value & mask;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("register read back", value & mask, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // full register set, written only once the block has gone quiet
    task automatic write_all(input int unsigned deb, input int unsigned lp,
                             input int unsigned ex, input int unsigned gr,
                             input int unsigned snd, input int unsigned lo,
                             input int unsigned hi, input int unsigned sp);
        drain();
        write_reg(iac_pkg::REG_DEBOUNCE, deb);
        write_reg(iac_pkg::REG_LONG_PRESS, lp);
        write_reg(iac_pkg::REG_EXIT_DELAY, ex);
        write_reg(iac_pkg::REG_GRACE, gr);
        write_reg(iac_pkg::REG_SOUND_LIMIT, snd);
        write_reg(iac_pkg::REG_NEAR_LOW, lo);
        write_reg(iac_pkg::REG_NEAR_HIGH, hi);
        write_reg(iac_pkg::REG_SENSOR_PER, sp);
    endtask

    // short timers so that random traffic walks through all states
    task automatic set_random_config();
        int unsigned lo;
        int unsigned hi;
        lo = $urandom_range(0, 4095);
        if ($urandom_range(0, 9) == 0)
            hi = $urandom_range(0, 4095);
        else
        begin
            hi = lo + $urandom_range(0, 800);
            if (hi > 4095)
                hi = 4095;
        end
        write_all($urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(1, 30),
                  $urandom_range(1, 30), $urandom_range(0, 4095), lo, hi,
                  $urandom_range(0, 5));
    endtask

    // sensor samples: mostly quiet, some hits, some right on the thresholds
    task automatic pick_sensors(output logic [11:0] snd, output logic [11:0] dst);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        snd  = 12'($urandom_range(0, cfg_sound_limit));
        if (cfg_near_low > 0 && $urandom_range(0, 1) == 1)
            dst = 12'($urandom_range(0, cfg_near_low - 1));
        else if (cfg_near_high < 4095)
            dst = 12'($urandom_range(cfg_near_high + 1, 4095));
        else
            dst = 12'($urandom_range(0, 4095));
        if (roll < 10)
        begin
            snd = (roll < 5) ? 12'(cfg_sound_limit) : 12'(cfg_sound_limit + 1);
            case (roll % 4)
                0:       dst = 12'(cfg_near_low);
                1:       dst = 12'(cfg_near_high);
                2:       dst = 12'(cfg_near_low - 1);
                default: dst = 12'(cfg_near_high + 1);
            endcase
        end
        else if (roll < 20 && cfg_sound_limit < 4095)
            snd = 12'($urandom_range(cfg_sound_limit + 1, 4095));
        else if (roll < 30 && cfg_near_low <= cfg_near_high)
            dst = 12'($urandom_range(cfg_near_low, cfg_near_high));
        else if (roll < 35)
        begin
            snd = 12'($urandom_range(0, 4095));
            dst = 12'($urandom_range(0, 4095));
        end
    endtask

    // random traffic built from presses, quiet runs, commands, bounce and noise
    task automatic gen_random(input int unsigned count);
        int unsigned stop;
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        int unsigned roll;
        logic [11:0] snd;
        logic [11:0] dst;
        logic [1:0]  cmd;
        stop = n_items + count;
        while (n_items < stop)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                // press of random length, then a release long enough to settle when debounce is short
                len = cfg_debounce + 2 + $urandom_range(0, cfg_long_press + cfg_debounce + 4);
                if (len > 60)
                    len = $urandom_range(1, 60);
                for (k = 0; k < len; k++)
                begin
                    pick_sensors(snd, dst);
                    push_tick(1'b1, snd, dst, iac_pkg::MODE_NONE);
                end
                len = cfg_debounce + 2;
                if (len > 60)
                    len = $urandom_range(1, 60);
                for (k = 0; k < len; k++)
                begin
                    pick_sensors(snd, dst);
                    push_tick(1'b0, snd, dst, iac_pkg::MODE_NONE);
                end
            end
            else if (kind < 55)
            begin
                len = $urandom_range(1, 25);
                for (k = 0; k < len; k++)
                begin
                    pick_sensors(snd, dst);
                    push_tick(1'b0, snd, dst, iac_pkg::MODE_NONE);
                end
            end
            else if (kind < 72)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    cmd = iac_pkg::MODE_ARM;
                else if (roll < 90)
                    cmd = iac_pkg::MODE_DISARM;
                else
                    cmd = MODE_UNKNOWN;
                pick_sensors(snd, dst);
                push_tick(1'b0, snd, dst, cmd);
            end
            else if (kind < 87)
            begin
                // contact bounce
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    pick_sensors(snd, dst);
                    push_tick(1'($urandom_range(0, 1)), snd, dst, iac_pkg::MODE_NONE);
                end
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    push_tick(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                              12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
            end
        end
    endtask

    // input driver: predicts each accepted word, then offers the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_status.push_back(step_alarm(tick_in));
            if (!in_valid || in_ready)
            begin
                if (tick_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    tick_in = tick_queue.pop_front();
                    touch_raw    <= tick_in.touch_raw;
                    sound_level  <= tick_in.sound_level;
                    distance_raw <= tick_in.distance_raw;
                    mode         <= tick_in.mode;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_status.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result word with nothing expected, state %0d",
                             $time, alarm_state);
                end
                else
                begin
                    oldest = expected_status.pop_front();
                    check_field("alarm_state", 32'(oldest.alarm_state), 32'(alarm_state));
                    check_field("lamp_drive", 32'(oldest.lamp_drive), 32'(lamp_drive));
                    check_field("light_on", 32'(oldest.light_on), 32'(light_on));
                    check_field("alarm_active", 32'(oldest.alarm_active),
                                32'(alarm_active));
                    check_field("siren_on", 32'(oldest.siren_on), 32'(siren_on));
                    check_field("siren_high", 32'(oldest.siren_high), 32'(siren_high));
                    check_field("chirp", 32'(oldest.chirp), 32'(chirp));
                    check_field("beep_count", 32'(oldest.beep_count), 32'(beep_count));
                    check_field("status_changed", 32'(oldest.status_changed),
                                32'(status_changed));
                    check_field("command_status", 32'(oldest.command_status),
                                32'(command_status));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // stimulus sequence
    initial
    begin
        int unsigned k;
        logic [11:0] snd;
        logic [11:0] dst;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // default registers: commands and field extremes
        push_tick(1'b0, 12'd0, 12'd0, MODE_UNKNOWN);
        push_tick(1'b0, 12'd4095, 12'd4095, iac_pkg::MODE_DISARM);
        push_tick(1'b1, 12'd4095, 12'd0, iac_pkg::MODE_ARM);
        push_tick(1'b0, 12'd0, 12'd4095, iac_pkg::MODE_ARM);
        push_tick(1'b0, 12'd200, 12'd249, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd201, 12'd695, iac_pkg::MODE_DISARM);

        // zero debounce, zero long press, sensors checked every armed tick
        write_all(0, 0, 2, 2, 100, 10, 20, 0);
        push_tick(1'b0, 12'd0, 12'd4095, iac_pkg::MODE_ARM);
        push_tick(1'b0, 12'd0, 12'd4095, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd100, 12'd9, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd100, 12'd21, iac_pkg::MODE_ARM);
        push_tick(1'b0, 12'd0, 12'd10, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        // long press fires as soon as the press is accepted: alarm stop
        push_tick(1'b1, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        push_tick(1'b1, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        // long press arms while a remote disarm lands in the same tick
        push_tick(1'b1, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        push_tick(1'b1, 12'd0, 12'd0, iac_pkg::MODE_DISARM);
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_NONE);
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_NONE);

        set_random_config();
        gen_random(100);

        set_random_config();
        send_idle_pct = 78;
        gen_random(50);
        drain();
        gen_random(50);

        set_random_config();
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        gen_random(100);

        set_random_config();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        gen_random(100);

        // reach the alarm quickly and stay long enough for the tone to flip
        write_all(2, 10, 3, 3, 0, 4095, 4095, 1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_ARM);
        for (k = 0; k < 6; k++)
            push_tick(1'b0, 12'd4095, 12'd0, iac_pkg::MODE_NONE);
        for (k = 0; k < 540; k++)
        begin
            pick_sensors(snd, dst);
            push_tick(1'b0, snd, dst, iac_pkg::MODE_NONE);
        end
        push_tick(1'b0, 12'd0, 12'd0, iac_pkg::MODE_DISARM);

        // largest 16-bit and 12-bit register values, empty near window
        write_all(1000, 65535, 65535, 65535, 4095, 4095, 0, 1000);
        send_idle_pct = 78;
        gen_random(50);

        // smallest nonzero timers, every check a hit
        write_all(0, 1, 1, 1, 0, 0, 4095, 1);
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        gen_random(60);

        set_random_config();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        gen_random(100);

        drain();
        repeat (10) @(posedge clk);
        if (expected_status.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_status.size());
        end
        if (n_errors == 0)
            $display("intrusion_alarm_controller_core verification clean");
        else
            $display("intrusion_alarm_controller_core verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("intrusion_alarm_controller_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/iac_pkg.sv
rtl/core/iac_step.sv
rtl/core/intrusion_alarm_controller_core.sv
bench/tb_intrusion_alarm_controller_core.sv
